>>> rtl/fbe_pkg.sv
// ----------------------------------------------------------------------------
// fbe_pkg
// Constants and round functions of the four-round Feistel block cipher:
// S-box and permutation tables, the round function and the key schedule.
// ----------------------------------------------------------------------------
package fbe_pkg;

   localparam int BLOCK_W = 64;
   localparam int HALF_W  = 32;
   localparam int KEY_W   = 64;
   localparam int ROUNDS  = 4;
   localparam int NIBBLES = HALF_W / 4;

   typedef logic [HALF_W-1:0] half_type;
   typedef logic [BLOCK_W-1:0] block_type;
   typedef half_type round_keys_type [ROUNDS];

   localparam logic [3:0] SBOX [NIBBLES][16] = '{
      '{4'd6,  4'd12, 4'd3,  4'd8,  4'd14, 4'd5,  4'd11, 4'd1,
        4'd2,  4'd4,  4'd13, 4'd7,  4'd0,  4'd10, 4'd15, 4'd9},
      '{4'd10, 4'd14, 4'd15, 4'd11, 4'd6,  4'd8,  4'd3,  4'd13,
        4'd7,  4'd9,  4'd2,  4'd12, 4'd1,  4'd0,  4'd4,  4'd5},
      '{4'd10, 4'd0,  4'd9,  4'd14, 4'd6,  4'd3,  4'd15, 4'd5,
        4'd1,  4'd13, 4'd12, 4'd7,  4'd11, 4'd4,  4'd2,  4'd8},
      '{4'd15, 4'd9,  4'd7,  4'd0,  4'd10, 4'd13, 4'd2,  4'd4,
        4'd3,  4'd6,  4'd12, 4'd5,  4'd1,  4'd8,  4'd14, 4'd11},
      '{4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
        4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9},
      '{4'd12, 4'd1,  4'd10, 4'd15, 4'd9,  4'd2,  4'd6,  4'd8,
        4'd0,  4'd13, 4'd3,  4'd4,  4'd14, 4'd7,  4'd5,  4'd11},
      '{4'd4,  4'd11, 4'd2,  4'd14, 4'd15, 4'd0,  4'd8,  4'd13,
        4'd3,  4'd12, 4'd9,  4'd7,  4'd5,  4'd10, 4'd6,  4'd1},
      '{4'd13, 4'd2,  4'd8,  4'd4,  4'd6,  4'd15, 4'd11, 4'd1,
        4'd10, 4'd9,  4'd3,  4'd14, 4'd5,  4'd0,  4'd12, 4'd7}
   };

   // output bit (31-i) takes input bit (32 - PBOX[i]), entries 1..32
   localparam logic [5:0] PBOX [HALF_W] = '{
      6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
      6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
      6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
      6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
   };

   function automatic half_type subst(input half_type x);
      half_type res;
      res = '0;
      for (int n = 0; n < NIBBLES; n++) begin
         res[HALF_W-1-4*n -: 4] = SBOX[n][x[HALF_W-1-4*n -: 4]];
      end
      return res;
   endfunction

   function automatic half_type perm(input half_type x);
      half_type   res;
      logic [5:0] src;
      res = '0;
      for (int i = 0; i < HALF_W; i++) begin
         src = 6'd32 - PBOX[i];
         res[HALF_W-1-i] = x[src[4:0]];
      end
      return res;
   endfunction

   function automatic half_type round_f(input half_type r, input half_type k);
      return perm(subst(r ^ k));
   endfunction

   function automatic round_keys_type make_keys(input logic [KEY_W-1:0] key);
      round_keys_type rk;
      for (int i = 0; i < HALF_W; i++) begin
         rk[0][HALF_W-1-i] = key[KEY_W-1-2*i];
         rk[2][HALF_W-1-i] = key[KEY_W-2-2*i];
      end
      rk[1] = key[KEY_W-1:HALF_W];
      rk[3] = key[HALF_W-1:0];
      return rk;
   endfunction

endpackage

>>> rtl/fbe_round.sv
// ----------------------------------------------------------------------------
// fbe_round
// One pipeline stage of the cipher: one Feistel round, halves swapped,
// with a valid bit and stall-aware load.
// ----------------------------------------------------------------------------
module fbe_round
   import fbe_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      up_valid,
   input  block_type up_block,
   input  half_type  round_key,
   output logic      up_ready,
   output logic      dn_valid,
   output block_type dn_block,
   input  logic      dn_ready
);

   logic      valid_ff;
   logic      valid_in;
   block_type block_ff;
   block_type block_in;
   half_type  left_new;

   assign up_ready = !valid_ff || dn_ready;
   assign left_new = up_block[BLOCK_W-1:HALF_W] ^ round_f(up_block[HALF_W-1:0], round_key);

   always_comb begin
      valid_in = valid_ff;
      block_in = block_ff;
      if (up_ready) begin
         valid_in = up_valid;
         block_in = {up_block[HALF_W-1:0], left_new};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      block_ff <= block_in;
   end

   assign dn_valid = valid_ff;
   assign dn_block = block_ff;

endmodule

>>> rtl/feistel_block_encrypt_top.sv
// ----------------------------------------------------------------------------
// feistel_block_encrypt_top
// Four-round Feistel block encryption, one round per pipeline stage.
// ----------------------------------------------------------------------------
// Takes one 64-bit plaintext beat per cycle and returns its ciphertext
// through the four registered round stages, each holding one round of
// S-boxes and bit permutation. Throughput is one beat per clock while
// rsp_stall is low; a stall backs up only the stages that hold data.
// The key is written through csr_wr_en/csr_wr_data and takes effect for
// beats accepted afterwards; write it only while the pipeline is empty.
module feistel_block_encrypt_top
   import fbe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [KEY_W-1:0]   csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [BLOCK_W-1:0] req_plaintext,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [BLOCK_W-1:0] rsp_ciphertext
);

   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in;
   round_keys_type   round_keys;

   logic      stage_valid [ROUNDS+1];
   block_type stage_block [ROUNDS+1];
   logic      stage_ready [ROUNDS+1];

   assign key_in = csr_wr_en ? csr_wr_data : key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign round_keys = make_keys(key_ff);

   assign stage_valid[0] = req_valid;
   assign stage_block[0] = req_plaintext;
   assign req_stall      = !stage_ready[0];

   for (genvar g = 0; g < ROUNDS; g++) begin : g_round
      fbe_round u_round (
         .clock     (clock),
         .reset     (reset),
         .up_valid  (stage_valid[g]),
         .up_block  (stage_block[g]),
         .round_key (round_keys[g]),
         .up_ready  (stage_ready[g]),
         .dn_valid  (stage_valid[g+1]),
         .dn_block  (stage_block[g+1]),
         .dn_ready  (stage_ready[g+1])
      );
   end

   // undo the swap of the last round
   assign stage_ready[ROUNDS] = !rsp_stall;
   assign rsp_valid           = stage_valid[ROUNDS];
   assign rsp_ciphertext      = {stage_block[ROUNDS][HALF_W-1:0],
                                 stage_block[ROUNDS][BLOCK_W-1:HALF_W]};

endmodule
